// ----- hdl/text_glyph_rect_renderer_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Text glyph rectangle renderer: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while the synchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef TEXT_GLYPH_RECT_RENDERER_UNIT_MACROS_SVH
`define TEXT_GLYPH_RECT_RENDERER_UNIT_MACROS_SVH

// Same-cycle implication.
`define GTR_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GTR_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/gtr_pkg.sv -----
// ----------------------------------------------------------------------------
// Text glyph rectangle renderer: package
// Types, register indexes, character codes and the 5x7 font shared by the
// renderer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gtr_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FG_COLOR  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_BG_COLOR  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SCALE     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_W  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_H  = 3'd6;

  localparam logic [7:0] CHAR_NEWLINE     = 8'd10;
  localparam logic [7:0] CHAR_FIRST_PRINT = 8'd32;
  localparam logic [7:0] CHAR_LAST_PRINT  = 8'd126;
  localparam logic [7:0] CHAR_QUESTION    = 8'd63;

  localparam int FONT_DEPTH = 95;

  typedef struct packed {
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    logic [3:0]  glyph_scale;
    logic [8:0]  screen_width;
    logic [8:0]  screen_height;
  } cfg_t;

  typedef struct packed {
    logic [15:0] color;
    logic [8:0]  h;
    logic [8:0]  w;
    logic [8:0]  y;
    logic [8:0]  x;
  } rect_t;

  typedef struct packed {
    logic  valid;
    logic  last;
    rect_t rect;
  } push_t;

  typedef struct packed {
    logic busy;
    logic pend_valid;
  } seq_status_t;

  // One entry per printable code, column 0 in the top byte, bit 0 of a
  // column is the top row.
  localparam logic [39:0] FONT [FONT_DEPTH] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
    40'h082A1C2A08, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0008142241, 40'h1414141414,
    40'h4122140800, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h7F2018207F, 40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
    40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
    40'h087E090102, 40'h081454543C, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h007F102844, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
    40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h08082A1C08
  };

endpackage

`default_nettype wire

// ----- hdl/gtr_clip.sv -----
// ----------------------------------------------------------------------------
// Text glyph rectangle renderer: clip unit
// Clips one candidate rectangle against the screen and says whether any of it
// is left. Shared by every cell of every glyph.
// ----------------------------------------------------------------------------
`default_nettype none

module gtr_clip (
  input  wire logic signed [15:0] x,
  input  wire logic signed [15:0] y,
  input  wire logic [6:0]         w,
  input  wire logic [6:0]         h,
  input  wire logic [15:0]        color,
  input  wire logic [8:0]         screen_width,
  input  wire logic [8:0]         screen_height,
  output      logic               keep,
  output      gtr_pkg::rect_t     rect
);
  import gtr_pkg::*;

  // Returns {keep, clipped start, clipped length} for one axis.
  function automatic logic [18:0] clip_dim(input logic signed [15:0] pos,
                                           input logic [6:0] len,
                                           input logic [8:0] lim);
    logic signed [17:0] p;
    logic signed [17:0] l;
    logic signed [17:0] m;
    logic               kp;
    p  = {{2{pos[15]}}, pos};
    l  = {11'd0, len};
    m  = {9'd0, lim};
    kp = (p < m);
    if (p < 0) begin
      l = l + p;
      p = '0;
    end
    if (p + l > m) begin
      l = m - p;
    end
    kp = kp && (l > 0);
    return {kp, p[8:0], l[8:0]};
  endfunction

  logic [18:0] cx;
  logic [18:0] cy;

  always_comb begin
    cx         = clip_dim(x, w, screen_width);
    cy         = clip_dim(y, h, screen_height);
    keep       = cx[18] && cy[18];
    rect.x     = cx[17:9];
    rect.w     = cx[8:0];
    rect.y     = cy[17:9];
    rect.h     = cy[8:0];
    rect.color = color;
  end

endmodule

`default_nettype wire

// ----- hdl/gtr_seq.sv -----
// ----------------------------------------------------------------------------
// Text glyph rectangle renderer: sequencer
// Keeps the text cursor, walks the glyph cells one per cycle unless stalled,
// through the clip unit. One clipped rectangle is held back to mark the last.
// ----------------------------------------------------------------------------
`default_nettype none

module gtr_seq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire gtr_pkg::cfg_t       cfg,
  input  wire logic                in_valid,
  input  wire logic [7:0]          in_code,
  input  wire logic                in_first,
  input  wire logic                out_can_take,
  output      gtr_pkg::push_t      push,
  output      gtr_pkg::seq_status_t status
);
  import gtr_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_RUN, S_FLUSH} state_t;

  localparam logic [2:0] SPACE_COL = 3'd5;
  localparam logic [2:0] LAST_ROW  = 3'd6;

  state_t      state_r, state_nxt;
  logic [7:0]  code_r, code_nxt;
  logic        first_r, first_nxt;
  logic [15:0] cursor_x_r, cursor_x_nxt;
  logic [15:0] cursor_y_r, cursor_y_nxt;
  logic [39:0] glyph_r, glyph_nxt;
  logic [2:0]  col_r, col_nxt;
  logic [2:0]  row_r, row_nxt;
  logic [6:0]  xoff_r, xoff_nxt;
  logic [6:0]  yoff_r, yoff_nxt;
  logic        pend_v_r, pend_v_nxt;
  rect_t       pend_r, pend_nxt;

  logic [3:0]  s;
  logic [6:0]  s7;
  logic [6:0]  s6;
  logic [6:0]  col_bits;
  logic        on;
  logic        is_space;
  logic        skip;
  logic [15:0] px;
  logic [15:0] py;
  logic [6:0]  cell_w;
  logic [6:0]  cell_h;
  logic [15:0] cell_color;
  logic        keep;
  rect_t       clipped;
  logic        cand;
  logic        stall;
  logic        cells_done;
  logic [15:0] base_x;
  logic [15:0] base_y;
  logic [7:0]  code_fix;
  logic [6:0]  font_idx;

  assign s  = cfg.glyph_scale;
  assign s7 = 7'({s, 3'b000}) - 7'(s);
  assign s6 = 7'({s, 2'b00}) + 7'({s, 1'b0});

  always_comb begin
    case (col_r)
      3'd0:    col_bits = glyph_r[38:32];
      3'd1:    col_bits = glyph_r[30:24];
      3'd2:    col_bits = glyph_r[22:16];
      3'd3:    col_bits = glyph_r[14:8];
      3'd4:    col_bits = glyph_r[6:0];
      default: col_bits = '0;
    endcase
  end

  assign is_space   = (col_r == SPACE_COL);
  assign on         = !is_space && col_bits[row_r];
  // At scale one a clear cell is left out, unless both colors match.
  assign skip       = !is_space && (s == 4'd1) && !on && (cfg.fg_color != cfg.bg_color);
  assign px         = cursor_x_r + {9'd0, xoff_r};
  assign py         = cursor_y_r + {9'd0, yoff_r};
  assign cell_w     = {3'd0, s};
  assign cell_h     = (is_space && (s != 4'd1)) ? s7 : {3'd0, s};
  assign cell_color = on ? cfg.fg_color : cfg.bg_color;

  gtr_clip u_clip (
    .x             ($signed(px)),
    .y             ($signed(py)),
    .w             (cell_w),
    .h             (cell_h),
    .color         (cell_color),
    .screen_width  (cfg.screen_width),
    .screen_height (cfg.screen_height),
    .keep          (keep),
    .rect          (clipped)
  );

  assign cand       = (state_r == S_RUN) && !skip && keep;
  assign stall      = cand && pend_v_r && !out_can_take;
  assign cells_done = is_space && ((s != 4'd1) || (row_r == LAST_ROW));

  assign base_x   = first_r ? cfg.origin_x : cursor_x_r;
  assign base_y   = first_r ? cfg.origin_y : cursor_y_r;
  assign code_fix = ((code_r < CHAR_FIRST_PRINT) || (code_r > CHAR_LAST_PRINT)) ?
                    CHAR_QUESTION : code_r;
  assign font_idx = 7'(code_fix - CHAR_FIRST_PRINT);

  always_comb begin
    push.valid = 1'b0;
    push.last  = 1'b0;
    push.rect  = pend_r;
    if (state_r == S_RUN) begin
      push.valid = cand && pend_v_r && out_can_take;
    end else if (state_r == S_FLUSH) begin
      push.valid = pend_v_r && out_can_take;
      push.last  = 1'b1;
    end
  end

  assign status.busy       = (state_r != S_IDLE);
  assign status.pend_valid = pend_v_r;

  always_comb begin
    state_nxt    = state_r;
    code_nxt     = code_r;
    first_nxt    = first_r;
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    glyph_nxt    = glyph_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    xoff_nxt     = xoff_r;
    yoff_nxt     = yoff_r;
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          code_nxt  = in_code;
          first_nxt = in_first;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (code_r == CHAR_NEWLINE) begin
          cursor_x_nxt = cfg.origin_x;
          cursor_y_nxt = base_y + 16'({s, 3'b000});
          state_nxt    = S_IDLE;
        end else begin
          cursor_x_nxt = base_x;
          cursor_y_nxt = base_y;
          glyph_nxt    = FONT[font_idx];
          col_nxt      = '0;
          row_nxt      = '0;
          xoff_nxt     = '0;
          yoff_nxt     = '0;
          pend_v_nxt   = 1'b0;
          state_nxt    = (s == 4'd0) ? S_FLUSH : S_RUN;
        end
      end
      S_RUN: begin
        if (!stall) begin
          if (cand) begin
            pend_v_nxt = 1'b1;
            pend_nxt   = clipped;
          end
          if (cells_done) begin
            state_nxt = S_FLUSH;
          end else if (!is_space && (row_r == LAST_ROW)) begin
            row_nxt  = '0;
            yoff_nxt = '0;
            col_nxt  = col_r + 3'd1;
            xoff_nxt = xoff_r + {3'd0, s};
          end else begin
            row_nxt  = row_r + 3'd1;
            yoff_nxt = yoff_r + {3'd0, s};
          end
        end
      end
      S_FLUSH: begin
        if (!pend_v_r || out_can_take) begin
          pend_v_nxt   = 1'b0;
          cursor_x_nxt = cursor_x_r + {9'd0, s6};
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cursor_x_r <= '0;
      cursor_y_r <= '0;
      pend_v_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
      pend_v_r   <= pend_v_nxt;
    end
    code_r  <= code_nxt;
    first_r <= first_nxt;
    glyph_r <= glyph_nxt;
    col_r   <= col_nxt;
    row_r   <= row_nxt;
    xoff_r  <= xoff_nxt;
    yoff_r  <= yoff_nxt;
    pend_r  <= pend_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/text_glyph_rect_renderer_unit.sv -----
// ----------------------------------------------------------------------------
// Text glyph rectangle renderer
// Turns character bytes into clipped fill rectangles from a 5x7 font and
// keeps a text cursor between characters.
// ----------------------------------------------------------------------------
//  channel | direction | word                              | side
//  in_     | slave     | tdata: char_code, tuser: first    | one character per word
//  out_    | master    | tdata: x,y,w,h,color, tlast: last | one rectangle per word
//  cfg_    | write     | cfg_addr, cfg_wdata               | register update, no wait
//
// A character goes through accept, glyph lookup, the clip unit one cell at a
// time (35 cells plus seven or one spacing cells), then close. Scale zero skips
// the cells; a newline ends after the lookup. in_tready is low while a character
// is worked. Reset clears the cursor. A stall on out_ holds the cell walk once
// one rectangle waits in the output register and another in the hold stage.
// ----------------------------------------------------------------------------
`default_nettype none

module text_glyph_rect_renderer_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output      logic                            in_tready,
  input  wire logic [7:0]                      in_tdata,  // [7:0] char_code
  input  wire logic                            in_tuser,  // [0] first
  output      logic                            out_tvalid,
  input  wire logic                            out_tready,
  // [8:0] rect_x, [17:9] rect_y, [26:18] rect_w, [35:27] rect_h,
  // [51:36] color, [55:52] zero
  output      logic [55:0]                     out_tdata,
  output      logic                            out_tlast,
  input  wire logic                            cfg_we,
  input  wire logic [gtr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [gtr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import gtr_pkg::*;

  cfg_t        cfg_r;
  logic        out_valid_r;
  logic        out_last_r;
  rect_t       out_rect_r;
  logic        out_can_take;
  push_t       push;
  seq_status_t status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x      <= '0;
      cfg_r.origin_y      <= '0;
      cfg_r.fg_color      <= 16'hFFFF;
      cfg_r.bg_color      <= '0;
      cfg_r.glyph_scale   <= 4'd1;
      cfg_r.screen_width  <= 9'd240;
      cfg_r.screen_height <= 9'd320;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ORIGIN_X: cfg_r.origin_x      <= cfg_wdata;
        REG_ORIGIN_Y: cfg_r.origin_y      <= cfg_wdata;
        REG_FG_COLOR: cfg_r.fg_color      <= cfg_wdata;
        REG_BG_COLOR: cfg_r.bg_color      <= cfg_wdata;
        REG_SCALE:    cfg_r.glyph_scale   <= cfg_wdata[3:0];
        REG_SCREEN_W: cfg_r.screen_width  <= cfg_wdata[8:0];
        REG_SCREEN_H: cfg_r.screen_height <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  assign out_can_take = !out_valid_r || out_tready;

  gtr_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_tvalid),
    .in_code      (in_tdata),
    .in_first     (in_tuser),
    .out_can_take (out_can_take),
    .push         (push),
    .status       (status)
  );

  assign in_tready = !status.busy;

  // Output register: loaded by the sequencer only when it is free or draining.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (push.valid) begin
      out_rect_r <= push.rect;
      out_last_r <= push.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_rect_r.color, out_rect_r.h, out_rect_r.w,
                       out_rect_r.y, out_rect_r.x};
  assign out_tlast  = out_last_r;

`include "text_glyph_rect_renderer_unit_macros.svh"

  `GTR_ASSERT_NXT(a_busy_after_in, clk, rst_n, in_tvalid && in_tready, !in_tready, "stayed ready")
  `GTR_ASSERT_IMP(a_push_has_room, clk, rst_n, push.valid, out_can_take, "output register full")
  `GTR_ASSERT_IMP(a_idle_empty, clk, rst_n, in_tready, !status.pend_valid, "rectangle held")

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text glyph rectangle renderer: testbench
// Streams character words into the renderer, predicts the clipped fill
// rectangles of every glyph from a local font table and cursor, and checks
// each rectangle word in order. Covers the reset settings, every cell mode,
// clipping at all edges and cursor wrap, then random strings under changing
// register settings and random idling on both channels.
// ----------------------------------------------------------------------------

module tb_top;
  import gtr_pkg::*;

  typedef struct {
    logic [8:0]  x;
    logic [8:0]  y;
    logic [8:0]  w;
    logic [8:0]  h;
    logic [15:0] color;
    logic        last;
  } rect_word_t;

  // Five columns per printable code, bit 0 of a column is the top row.
  localparam logic [7:0] GLYPH_COLS [475] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h5F,8'h00,8'h00, 8'h00,8'h07,8'h00,8'h07,8'h00,
    8'h14,8'h7F,8'h14,8'h7F,8'h14, 8'h24,8'h2A,8'h7F,8'h2A,8'h12, 8'h23,8'h13,8'h08,8'h64,8'h62,
    8'h36,8'h49,8'h55,8'h22,8'h50, 8'h00,8'h05,8'h03,8'h00,8'h00, 8'h00,8'h1C,8'h22,8'h41,8'h00,
    8'h00,8'h41,8'h22,8'h1C,8'h00, 8'h08,8'h2A,8'h1C,8'h2A,8'h08, 8'h08,8'h08,8'h3E,8'h08,8'h08,
    8'h00,8'h50,8'h30,8'h00,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08, 8'h00,8'h60,8'h60,8'h00,8'h00,
    8'h20,8'h10,8'h08,8'h04,8'h02, 8'h3E,8'h51,8'h49,8'h45,8'h3E, 8'h00,8'h42,8'h7F,8'h40,8'h00,
    8'h42,8'h61,8'h51,8'h49,8'h46, 8'h21,8'h41,8'h45,8'h4B,8'h31, 8'h18,8'h14,8'h12,8'h7F,8'h10,
    8'h27,8'h45,8'h45,8'h45,8'h39, 8'h3C,8'h4A,8'h49,8'h49,8'h30, 8'h01,8'h71,8'h09,8'h05,8'h03,
    8'h36,8'h49,8'h49,8'h49,8'h36, 8'h06,8'h49,8'h49,8'h29,8'h1E, 8'h00,8'h36,8'h36,8'h00,8'h00,
    8'h00,8'h56,8'h36,8'h00,8'h00, 8'h00,8'h08,8'h14,8'h22,8'h41, 8'h14,8'h14,8'h14,8'h14,8'h14,
    8'h41,8'h22,8'h14,8'h08,8'h00, 8'h02,8'h01,8'h51,8'h09,8'h06, 8'h32,8'h49,8'h79,8'h41,8'h3E,
    8'h7E,8'h11,8'h11,8'h11,8'h7E, 8'h7F,8'h49,8'h49,8'h49,8'h36, 8'h3E,8'h41,8'h41,8'h41,8'h22,
    8'h7F,8'h41,8'h41,8'h22,8'h1C, 8'h7F,8'h49,8'h49,8'h49,8'h41, 8'h7F,8'h09,8'h09,8'h01,8'h01,
    8'h3E,8'h41,8'h41,8'h51,8'h32, 8'h7F,8'h08,8'h08,8'h08,8'h7F, 8'h00,8'h41,8'h7F,8'h41,8'h00,
    8'h20,8'h40,8'h41,8'h3F,8'h01, 8'h7F,8'h08,8'h14,8'h22,8'h41, 8'h7F,8'h40,8'h40,8'h40,8'h40,
    8'h7F,8'h02,8'h04,8'h02,8'h7F, 8'h7F,8'h04,8'h08,8'h10,8'h7F, 8'h3E,8'h41,8'h41,8'h41,8'h3E,
    8'h7F,8'h09,8'h09,8'h09,8'h06, 8'h3E,8'h41,8'h51,8'h21,8'h5E, 8'h7F,8'h09,8'h19,8'h29,8'h46,
    8'h46,8'h49,8'h49,8'h49,8'h31, 8'h01,8'h01,8'h7F,8'h01,8'h01, 8'h3F,8'h40,8'h40,8'h40,8'h3F,
    8'h1F,8'h20,8'h40,8'h20,8'h1F, 8'h7F,8'h20,8'h18,8'h20,8'h7F, 8'h63,8'h14,8'h08,8'h14,8'h63,
    8'h03,8'h04,8'h78,8'h04,8'h03, 8'h61,8'h51,8'h49,8'h45,8'h43, 8'h00,8'h00,8'h7F,8'h41,8'h41,
    8'h02,8'h04,8'h08,8'h10,8'h20, 8'h41,8'h41,8'h7F,8'h00,8'h00, 8'h04,8'h02,8'h01,8'h02,8'h04,
    8'h40,8'h40,8'h40,8'h40,8'h40, 8'h00,8'h01,8'h02,8'h04,8'h00, 8'h20,8'h54,8'h54,8'h54,8'h78,
    8'h7F,8'h48,8'h44,8'h44,8'h38, 8'h38,8'h44,8'h44,8'h44,8'h20, 8'h38,8'h44,8'h44,8'h48,8'h7F,
    8'h38,8'h54,8'h54,8'h54,8'h18, 8'h08,8'h7E,8'h09,8'h01,8'h02, 8'h08,8'h14,8'h54,8'h54,8'h3C,
    8'h7F,8'h08,8'h04,8'h04,8'h78, 8'h00,8'h44,8'h7D,8'h40,8'h00, 8'h20,8'h40,8'h44,8'h3D,8'h00,
    8'h00,8'h7F,8'h10,8'h28,8'h44, 8'h00,8'h41,8'h7F,8'h40,8'h00, 8'h7C,8'h04,8'h18,8'h04,8'h78,
    8'h7C,8'h08,8'h04,8'h04,8'h78, 8'h38,8'h44,8'h44,8'h44,8'h38, 8'h7C,8'h14,8'h14,8'h14,8'h08,
    8'h08,8'h14,8'h14,8'h18,8'h7C, 8'h7C,8'h08,8'h04,8'h04,8'h08, 8'h48,8'h54,8'h54,8'h54,8'h20,
    8'h04,8'h3F,8'h44,8'h40,8'h20, 8'h3C,8'h40,8'h40,8'h20,8'h7C, 8'h1C,8'h20,8'h40,8'h20,8'h1C,
    8'h3C,8'h40,8'h30,8'h40,8'h3C, 8'h44,8'h28,8'h10,8'h28,8'h44, 8'h0C,8'h50,8'h50,8'h50,8'h3C,
    8'h44,8'h64,8'h54,8'h4C,8'h44, 8'h00,8'h08,8'h36,8'h41,8'h00, 8'h00,8'h00,8'h7F,8'h00,8'h00,
    8'h00,8'h41,8'h36,8'h08,8'h00, 8'h08,8'h08,8'h2A,8'h1C,8'h08
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;   // [7:0] char_code
  logic                  in_tuser = 1'b0; // [0] first
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [8:0] rect_x, [17:9] rect_y, [26:18] rect_w, [35:27] rect_h,
  // [51:36] color, [55:52] zero
  logic [55:0]           out_tdata;
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Register mirror and text cursor, at their reset values.
  logic [15:0] mir_org_x = 16'd0;
  logic [15:0] mir_org_y = 16'd0;
  logic [15:0] mir_fg = 16'hFFFF;
  logic [15:0] mir_bg = 16'h0000;
  logic [3:0]  mir_scale = 4'd1;
  logic [8:0]  mir_scr_w = 9'd240;
  logic [8:0]  mir_scr_h = 9'd320;
  logic [15:0] text_x = 16'd0;
  logic [15:0] text_y = 16'd0;

  rect_word_t rect_expect_q[$];
  rect_word_t glyph_rects[$];

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int chars_sent = 0;
  int rects_checked = 0;
  int settings_used = 0;
  int n_errors = 0;

  text_glyph_rect_renderer_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic int wrap16(input logic [15:0] v);
    return int'($signed(v));
  endfunction

  // Clips one cell to the screen and queues it unless nothing is left.
  function automatic void clip_rect(input int x, input int y, input int w, input int h,
                                    input logic [15:0] color);
    int sw;
    int sh;
    rect_word_t r;
    sw = int'(mir_scr_w);
    sh = int'(mir_scr_h);
    if (x >= sw || y >= sh) return;
    if (x < 0) begin
      w = w + x;
      x = 0;
    end
    if (y < 0) begin
      h = h + y;
      y = 0;
    end
    if (x + w > sw) w = sw - x;
    if (y + h > sh) h = sh - y;
    if (w <= 0 || h <= 0) return;
    r.x = x[8:0];
    r.y = y[8:0];
    r.w = w[8:0];
    r.h = h[8:0];
    r.color = color;
    r.last = 1'b0;
    glyph_rects.push_back(r);
  endfunction

  function automatic void predict_glyph_rects(input logic [7:0] code, input logic first);
    int s;
    int cx;
    int cy;
    logic [7:0] glyph;
    logic [7:0] bits;
    logic on;
    s = int'(mir_scale);
    glyph_rects.delete();
    if (first) begin
      text_x = mir_org_x;
      text_y = mir_org_y;
    end
    if (code == CHAR_NEWLINE) begin
      text_y = text_y + 16'(8 * s);
      text_x = mir_org_x;
      return;
    end
    glyph = (code < CHAR_FIRST_PRINT || code > CHAR_LAST_PRINT) ? CHAR_QUESTION : code;
    cx = wrap16(text_x);
    cy = wrap16(text_y);
    if (s != 0) begin
      for (int col = 0; col < 5; col++) begin
        bits = GLYPH_COLS[(int'(glyph) - 32) * 5 + col];
        for (int row = 0; row < 7; row++) begin
          on = bits[row];
          // At scale one a clear cell is only drawn when both colors match.
          if (s == 1 && !on && mir_fg != mir_bg) continue;
          clip_rect(wrap16(16'(cx + col * s)), wrap16(16'(cy + row * s)), s, s,
                    on ? mir_fg : mir_bg);
        end
      end
      if (s == 1) begin
        for (int row = 0; row < 7; row++)
          clip_rect(wrap16(16'(cx + 5)), wrap16(16'(cy + row)), 1, 1, mir_bg);
      end else begin
        clip_rect(wrap16(16'(cx + 5 * s)), cy, s, 7 * s, mir_bg);
      end
    end
    text_x = text_x + 16'(6 * s);
    if (glyph_rects.size() > 0) glyph_rects[glyph_rects.size() - 1].last = 1'b1;
    foreach (glyph_rects[i]) rect_expect_q.push_back(glyph_rects[i]);
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      n_errors++;
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    rect_word_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (rect_expect_q.size() == 0) begin
        n_errors++;
        $error("rectangle word with none expected: %h", out_tdata);
      end else begin
        exp_r = rect_expect_q.pop_front();
        check_field("rect_x", int'(exp_r.x), int'(out_tdata[8:0]));
        check_field("rect_y", int'(exp_r.y), int'(out_tdata[17:9]));
        check_field("rect_w", int'(exp_r.w), int'(out_tdata[26:18]));
        check_field("rect_h", int'(exp_r.h), int'(out_tdata[35:27]));
        check_field("color", int'(exp_r.color), int'(out_tdata[51:36]));
        check_field("last", int'(exp_r.last), int'(out_tlast));
        rects_checked++;
      end
    end
  end

  task automatic send_char(input logic [7:0] code, input logic first);
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    in_tuser  <= first;
    do @(posedge clk); while (!in_tready);
    predict_glyph_rects(code, first);
    chars_sent++;
  endtask

  // Holds the input until every rectangle is out and the block has settled.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (rect_expect_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic apply_setup(input logic [15:0] org_x, input logic [15:0] org_y,
                             input logic [15:0] fg, input logic [15:0] bg,
                             input logic [3:0] scale, input logic [8:0] scr_w,
                             input logic [8:0] scr_h);
    logic [15:0] vals [7];
    vals = '{org_x, org_y, fg, bg, 16'(scale), 16'(scr_w), 16'(scr_h)};
    for (int idx = 0; idx < 7; idx++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= CFG_ADDR_W'(idx);
      cfg_wdata <= vals[idx];
      @(posedge clk);
      case (CFG_ADDR_W'(idx))
        REG_ORIGIN_X: mir_org_x = vals[idx];
        REG_ORIGIN_Y: mir_org_y = vals[idx];
        REG_FG_COLOR: mir_fg = vals[idx];
        REG_BG_COLOR: mir_bg = vals[idx];
        REG_SCALE:    mir_scale = vals[idx][3:0];
        REG_SCREEN_W: mir_scr_w = vals[idx][8:0];
        REG_SCREEN_H: mir_scr_h = vals[idx][8:0];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [15:0] pick_origin(input int span);
    case ($urandom_range(9))
      0: return 16'h8000 + 16'($urandom_range(40));
      1: return 16'h7FFF - 16'($urandom_range(40));
      2: return 16'($urandom);
      default: return 16'($urandom_range(span + 40) - 30);
    endcase
  endfunction

  function automatic logic [8:0] pick_screen();
    case ($urandom_range(7))
      0: return 9'd320;
      1: return 9'($urandom_range(1, 12));
      default: return 9'($urandom_range(100, 320));
    endcase
  endfunction

  function automatic logic [3:0] pick_scale();
    case ($urandom_range(9))
      0: return 4'd0;
      1: return 4'd15;
      2, 3: return 4'($urandom_range(2, 15));
      default: return 4'($urandom_range(1, 3));
    endcase
  endfunction

  function automatic logic [7:0] pick_char();
    case ($urandom_range(19))
      0, 1: return CHAR_NEWLINE;
      2: return 8'($urandom_range(255));
      3: return 8'($urandom_range(31));
      default: return 8'($urandom_range(CHAR_FIRST_PRINT, CHAR_LAST_PRINT));
    endcase
  endfunction

  task automatic apply_random_setup();
    logic [8:0]  w;
    logic [8:0]  h;
    logic [15:0] fg;
    w = pick_screen();
    h = pick_screen();
    fg = 16'($urandom);
    apply_setup(pick_origin(int'(w)), pick_origin(int'(h)), fg,
                ($urandom_range(5) == 0) ? fg : 16'($urandom), pick_scale(), w, h);
  endtask

  // Reset settings: cursor at zero, white on black, scale one, 240 by 320.
  task automatic test_power_up_defaults();
    send_char("A", 1'b0);
    send_char(8'd0, 1'b0);
    send_char(8'd255, 1'b0);
    send_char(8'd127, 1'b0);
    send_char(8'd31, 1'b0);
    send_char(" ", 1'b0);
    send_char("~", 1'b0);
    send_char(CHAR_NEWLINE, 1'b0);
    send_char("g", 1'b1);
  endtask

  task automatic test_cell_modes();
    // Scale one with equal colors draws the clear cells too.
    wait_idle();
    apply_setup(16'd10, 16'd20, 16'h1234, 16'h1234, 4'd1, 9'd240, 9'd320);
    send_char("W", 1'b1);
    // Scale zero draws nothing and leaves the cursor where it is.
    wait_idle();
    apply_setup(16'd0, 16'd0, 16'hF800, 16'h001F, 4'd0, 9'd240, 9'd320);
    send_char("M", 1'b1);
    send_char(CHAR_NEWLINE, 1'b0);
    send_char("M", 1'b0);
    wait_idle();
    apply_setup(16'd3, 16'd5, 16'h0000, 16'hFFFF, 4'd15, 9'd320, 9'd320);
    send_char("#", 1'b1);
    wait_idle();
    apply_setup(16'd100, 16'd100, 16'h07E0, 16'hAAAA, 4'd2, 9'd240, 9'd320);
    send_char("%", 1'b1);
  endtask

  task automatic test_clipping_edges();
    wait_idle();
    apply_setup(-16'sd7, -16'sd3, 16'hFFFF, 16'h0841, 4'd2, 9'd240, 9'd320);
    send_char("B", 1'b1);
    wait_idle();
    apply_setup(16'd0, 16'd0, 16'hFFFF, 16'h0000, 4'd1, 9'd1, 9'd1);
    send_char("H", 1'b1);
    send_char("H", 1'b0);
    wait_idle();
    apply_setup(16'd315, 16'd316, 16'h5555, 16'h0000, 4'd3, 9'd320, 9'd320);
    send_char("@", 1'b1);
    // The cursor runs past the top of the signed range and wraps.
    wait_idle();
    apply_setup(16'd32766, 16'd100, 16'hFFFF, 16'h0000, 4'd1, 9'd240, 9'd320);
    send_char("X", 1'b1);
    send_char("X", 1'b0);
    wait_idle();
    apply_setup(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 4'd15, 9'd320, 9'd320);
    send_char("Z", 1'b1);
    send_char(CHAR_NEWLINE, 1'b0);
    wait_idle();
    apply_setup(16'd0, 16'd32760, 16'hC618, 16'h0000, 4'd15, 9'd320, 9'd320);
    send_char(CHAR_NEWLINE, 1'b1);
    send_char("Q", 1'b0);
  endtask

  // Mostly strings that start at the origin, with newlines, unprintable
  // bytes and stray reloads of the cursor mixed in.
  task automatic test_random_text(input int gap_pct, input int stall_pct, input int n_chars);
    int start;
    int len;
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    start = chars_sent;
    while (chars_sent - start < n_chars) begin
      wait_idle();
      apply_random_setup();
      len = $urandom_range(8, 30);
      for (int i = 0; i < len && chars_sent - start < n_chars; i++)
        send_char(pick_char(), (i == 0) || ($urandom_range(24) == 0));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_gap_pct = 18;
    recv_stall_pct = 69;
    test_power_up_defaults();
    test_cell_modes();
    test_clipping_edges();
    test_random_text(18, 69, 112);
    test_random_text(69, 18, 112);
    test_random_text(0, 0, 112);
    wait_idle();
    $display("Sent %0d characters under %0d register settings; %0d rectangles checked.",
             chars_sent, settings_used, rects_checked);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d rectangles still outstanding.", rect_expect_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/gtr_pkg.sv
hdl/gtr_clip.sv
hdl/gtr_seq.sv
hdl/text_glyph_rect_renderer_unit.sv
bench/tb_top.sv
